[hw/rtl/pmdlp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmdlp_pkg
// Shared sizes, codes and reset values for the port-mapped display and LED
// panel.
// ----------------------------------------------------------------------------
package pmdlp_pkg;

   localparam int TITLE_LENGTH = 20;
   localparam int DIGIT_COUNT  = 10;

   localparam int CHAR_W  = 7;
   localparam int DIGIT_W = 5;

   // Request and response bus widths.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 208;

   localparam logic       MODE_READ  = 1'b0;
   localparam logic       MODE_WRITE = 1'b1;

   localparam logic [1:0] PORT_KEYS    = 2'd0;
   localparam logic [1:0] PORT_TITLE   = 2'd1;
   localparam logic [1:0] PORT_LEDS    = 2'd2;
   localparam logic [1:0] PORT_CONTROL = 2'd3;

   // Control bit positions on ports 1 and 3.
   localparam int BIT_TITLE_STROBE = 7;
   localparam int BIT_USER_LED     = 7;
   localparam int BIT_SPEAKER      = 6;
   localparam int BIT_DIGIT_LATCH  = 5;
   localparam int BIT_DIGIT_SHIFT  = 4;

   localparam logic [7:0]         PREV_RESET  = 8'hff;
   localparam logic [7:0]         IDLE_READ   = 8'hff;
   localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 7'd32;
   localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 5'd16;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [DIGIT_W-1:0] digit_type;

endpackage
`default_nettype wire

[hw/rtl/port_mapped_display_led_panel_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// port_mapped_display_led_panel_unit
// Port access engine: key read-back, scrolling title, LEDs, speaker and a
// latched ten-digit display, with a two-deep response buffer.
// ----------------------------------------------------------------------------
// Channel   Direction  Width  Contents
// req_*     in         24     mode, port, write_data, key_state
// rsp_*     out        208    read_data ... title_high (see port list)
//
// One request is taken per cycle while req_tready is high.
// State is updated at the edge that accepts the request, and the response
// is formed from the updated state by one level of logic.
// A main response register plus one skid register keep req_tready high
// while a single response waits; req_tready falls only when both are full.
// Reset is synchronous and returns every panel register to its idle value.
// ----------------------------------------------------------------------------
module port_mapped_display_led_panel_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // mode[0], port[2:1], write_data[10:3], key_state[18:11], zero [23:19]
   input  wire logic [pmdlp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // read_data[7:0], led_bits[15:8], user_led[16], speaker[17],
   // shown_digits[67:18], title_low[130:68], title_mid[193:131],
   // title_high[207:194]
   output logic [pmdlp_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import pmdlp_pkg::*;

   logic       req_mode;
   logic [1:0] req_port;
   logic [7:0] req_data;
   logic [7:0] req_keys;

   logic accept;
   logic take;

   logic [7:0] prev_p1_ff,  prev_p1_in;
   logic [7:0] prev_p3_ff,  prev_p3_in;
   logic [7:0] led_ff,      led_in;
   logic       user_led_ff, user_led_in;
   logic       speaker_ff,  speaker_in;
   char_type   title_ff       [TITLE_LENGTH];
   char_type   title_in       [TITLE_LENGTH];
   digit_type  digit_shift_ff [DIGIT_COUNT];
   digit_type  digit_shift_in [DIGIT_COUNT];
   digit_type  digit_shown_ff [DIGIT_COUNT];
   digit_type  digit_shown_in [DIGIT_COUNT];

   logic [7:0]   read_value;
   logic [139:0] title_flat;
   logic [49:0]  digits_flat;
   logic [RSP_DATA_W-1:0] result;

   logic                  out_valid_ff,  out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff,   out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0] skid_data_ff,  skid_data_in;

   assign req_mode = req_tdata[0];
   assign req_port = req_tdata[2:1];
   assign req_data = req_tdata[10:3];
   assign req_keys = req_tdata[18:11];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   // Next panel state for the request on the bus.
   always_comb begin
      logic [7:0] rise;
      rise        = (prev_p3_ff ^ req_data) & req_data;
      prev_p1_in  = prev_p1_ff;
      prev_p3_in  = prev_p3_ff;
      led_in      = led_ff;
      user_led_in = user_led_ff;
      speaker_in  = speaker_ff;
      title_in       = title_ff;
      digit_shift_in = digit_shift_ff;
      digit_shown_in = digit_shown_ff;
      read_value  = IDLE_READ;

      if (req_mode == MODE_READ) begin
         if (req_port == PORT_KEYS) begin
            read_value = req_keys;
         end
      end else begin
         unique case (req_port)
            PORT_KEYS: begin
            end
            PORT_TITLE: begin
               if (req_data[BIT_TITLE_STROBE] && !prev_p1_ff[BIT_TITLE_STROBE]) begin
                  for (int i = 0; i < TITLE_LENGTH - 1; i++) begin
                     title_in[i] = title_ff[i + 1];
                  end
                  title_in[TITLE_LENGTH - 1] = req_data[CHAR_W-1:0];
               end
               prev_p1_in = req_data;
            end
            PORT_LEDS: begin
               led_in = req_data;
            end
            PORT_CONTROL: begin
               prev_p3_in = req_data;
               if (rise[BIT_USER_LED]) begin
                  user_led_in = !user_led_ff;
               end
               if (rise[BIT_SPEAKER]) begin
                  speaker_in = !speaker_ff;
               end
               // The latch copies the shift register as it stood before
               // any shift in the same write.
               if (rise[BIT_DIGIT_LATCH]) begin
                  digit_shown_in = digit_shift_ff;
               end
               if (rise[BIT_DIGIT_SHIFT]) begin
                  for (int i = 1; i < DIGIT_COUNT; i++) begin
                     digit_shift_in[i] = digit_shift_ff[i - 1];
                  end
                  digit_shift_in[0] = {1'b0, req_data[3:0]};
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Pack the response from the updated state; read_data is 8'hff but on a key read.
   always_comb begin
      title_flat  = '0;
      digits_flat = '0;
      for (int i = 0; i < TITLE_LENGTH; i++) begin
         title_flat[CHAR_W*i +: CHAR_W] = title_in[i];
      end
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         digits_flat[DIGIT_W*i +: DIGIT_W] = digit_shown_in[i];
      end
      result = {title_flat, digits_flat, speaker_in, user_led_in, led_in, read_value};
   end

   // Response buffer: the skid register fills only while the main one stalls.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_p1_ff    <= PREV_RESET;
         prev_p3_ff    <= PREV_RESET;
         led_ff        <= '0;
         user_led_ff   <= 1'b0;
         speaker_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < TITLE_LENGTH; i++) begin
            title_ff[i] <= CHAR_SPACE;
         end
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_shift_ff[i] <= DIGIT_BLANK;
            digit_shown_ff[i] <= DIGIT_BLANK;
         end
      end else begin
         if (accept) begin
            prev_p1_ff     <= prev_p1_in;
            prev_p3_ff     <= prev_p3_in;
            led_ff         <= led_in;
            user_led_ff    <= user_led_in;
            speaker_ff     <= speaker_in;
            title_ff       <= title_in;
            digit_shift_ff <= digit_shift_in;
            digit_shown_ff <= digit_shown_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

[hw/rtl/pmdlp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmdlp_checker
// Port-level checks on the panel unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module pmdlp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [pmdlp_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [pmdlp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pmdlp_pkg::*;

   // No response is offered straight after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response offered after reset");

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Back-pressure only appears when a response is already waiting.
   a_ready_buffer: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request refused with an empty response buffer");

   // With an empty output, an accepted request yields a response next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> rsp_tvalid)
      else $error("response missing one cycle after request");

   // A key read with an empty output returns the key bits of that request.
   a_key_read: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && req_tdata[0] == MODE_READ
      && req_tdata[2:1] == PORT_KEYS |=> rsp_tdata[7:0] == $past(req_tdata[18:11]))
      else $error("key read returned wrong data");

endmodule

bind port_mapped_display_led_panel_unit pmdlp_checker u_pmdlp_checker (.*);
`default_nettype wire
